// ===== rtl/avds_pkg.sv =====
// ----------------------------------------------------------------------------
// avds_pkg
// Shared widths, constants and types for the active vertex displacement step.
// ----------------------------------------------------------------------------
package avds_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;

  localparam int ANGLE_W    = 16;
  localparam int MOT_W      = 16;
  localparam int FORCE_W    = 32;
  localparam int DISP_W     = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 8;

  localparam int CORDIC_ITERS     = 30;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CORDIC_STAGES    = CORDIC_ITERS / CORDIC_PER_STAGE;
  // input register, iteration stages, quadrant map, round/clamp
  localparam int CORDIC_LAT       = CORDIC_STAGES + 3;

  localparam int TRIG_W = TRIG_FRAC_BITS + 2;

  typedef logic signed [31:0]       cordic_word_t;
  typedef logic signed [TRIG_W-1:0] trig_t;

  localparam cordic_word_t CORDIC_GAIN = 32'sd652032874;

  localparam cordic_word_t ATAN_TURN [CORDIC_ITERS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,
    32'sd41,        32'sd20,        32'sd10,        32'sd5,
    32'sd3,         32'sd1
  };

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } quad_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP = 8'd0,
    REG_MOBILITY  = 8'd1
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] TIME_STEP_RST = 16'd655;
  localparam logic [CFG_DATA_W-1:0] MOBILITY_RST  = 16'd256;

endpackage

// ===== rtl/avds_if.sv =====
// ----------------------------------------------------------------------------
// avds_if
// Valid/ready channels: vertex items in, displacement items out, config writes.
// ----------------------------------------------------------------------------
interface avds_vertex_if import avds_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [MOT_W-1:0]   motility_a;
  logic        [MOT_W-1:0]   motility_b;
  logic        [MOT_W-1:0]   motility_c;
  logic        [ANGLE_W-1:0] angle_a;
  logic        [ANGLE_W-1:0] angle_b;
  logic        [ANGLE_W-1:0] angle_c;
  logic signed [FORCE_W-1:0] force_x;
  logic signed [FORCE_W-1:0] force_y;
  logic                      last_vertex;

  modport source (
    output valid, motility_a, motility_b, motility_c, angle_a, angle_b, angle_c,
           force_x, force_y, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, motility_a, motility_b, motility_c, angle_a, angle_b, angle_c,
           force_x, force_y, last_vertex,
    output ready
  );
endinterface

interface avds_disp_if import avds_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DISP_W-1:0] disp_x;
  logic signed [DISP_W-1:0] disp_y;
  logic                     sweep_end;
  logic                     saturated;

  modport source (output valid, disp_x, disp_y, sweep_end, saturated, input ready);
  modport sink   (input valid, disp_x, disp_y, sweep_end, saturated, output ready);
endinterface

interface avds_cfg_if import avds_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// ===== rtl/active_vertex_displacement_step.sv =====
// ----------------------------------------------------------------------------
// active_vertex_displacement_step
// One overdamped Euler step per vertex: dt * (mean cell director + mu * force).
//
//   channel  dir  handshake       payload
//   cfg      in   valid/ready     idx, data (time_step, mobility)
//   vtx      in   valid/ready     motility_a..c, angle_a..c, force_x/y, last_vertex
//   disp     out  valid/ready     disp_x, disp_y, sweep_end, saturated
//
// One item per cycle while disp takes the output; the path is the pipelined
// CORDIC followed by the divide-by-three and output multiply stages.
// The whole pipeline advances together; it holds while the last stage has an
// item that disp does not take. Reset clears the valid bits and loads the
// register defaults. Config writes are always taken.
// ----------------------------------------------------------------------------
module active_vertex_displacement_step import avds_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  avds_cfg_if.sink    cfg,
  avds_vertex_if.sink vtx,
  avds_disp_if.source disp
);

  localparam int NST    = CORDIC_LAT + 11;
  localparam int T0     = CORDIC_LAT - 1;
  localparam int PROD_W = TRIG_W + MOT_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int K_SH   = TRIG_FRAC_BITS - 4;
  localparam int HALF_D = 3 << (K_SH - 1);
  localparam int T_W    = SUM_W + 1 - K_SH;
  localparam logic [T_W-1:0] RECIP3 = T_W'((64'd1 << T_W) / 3);
  localparam int FP_W   = FORCE_W + CFG_DATA_W;
  localparam int FT_W   = FP_W - 8 + 2;
  localparam int INX_W  = FT_W + 1;
  localparam int LO_W   = (INX_W + 1) / 2;
  localparam int HI_W   = INX_W - LO_W;
  localparam int FULL_W = CFG_DATA_W + INX_W + 1;
  localparam int OM_W   = FULL_W - 16;

  typedef struct packed {
    logic        [MOT_W-1:0]   mot_a;
    logic        [MOT_W-1:0]   mot_b;
    logic        [MOT_W-1:0]   mot_c;
    logic signed [FORCE_W-1:0] fx;
    logic signed [FORCE_W-1:0] fy;
    logic                      last;
  } side_t;

  logic [CFG_DATA_W-1:0] time_step;
  logic [CFG_DATA_W-1:0] mobility;

  logic           en;
  logic [NST-1:0] vld;
  side_t          sd [CORDIC_LAT];
  logic [10:0]    last_d;

  trig_t cos_t [3];
  trig_t sin_t [3];
  trig_t trig  [2][3];
  logic [MOT_W-1:0]          mot  [3];
  logic signed [FORCE_W-1:0] frc  [2];

  // stage registers, index 0 = x, 1 = y
  logic signed [PROD_W-1:0] prod  [2][3];
  logic [FORCE_W-1:0]       fmag  [2];
  logic                     fneg1 [2];
  logic signed [SUM_W-1:0]  sum   [2];
  logic [FP_W-1:0]          fp    [2];
  logic                     fneg2 [2];
  logic [T_W-1:0]           t3    [2];
  logic                     sneg3 [2];
  logic signed [FT_W-1:0]   ft3   [2];
  logic [2*T_W-1:0]         tr4   [2];
  logic [T_W-1:0]           t4    [2];
  logic                     sneg4 [2];
  logic signed [FT_W-1:0]   ft4   [2];
  logic [T_W-1:0]           q05   [2];
  logic [2:0]               r5    [2];
  logic                     sneg5 [2];
  logic signed [FT_W-1:0]   ft5   [2];
  logic signed [T_W:0]      dir6  [2];
  logic signed [FT_W-1:0]   ft6   [2];
  logic signed [INX_W-1:0]  inx7  [2];
  logic [INX_W-1:0]         imag8 [2];
  logic                     ineg8 [2];
  logic [CFG_DATA_W+LO_W-1:0] plo9 [2];
  logic [CFG_DATA_W+HI_W-1:0] phi9 [2];
  logic                     ineg9 [2];
  logic [OM_W-1:0]          om10  [2];
  logic                     ineg10 [2];
  logic signed [DISP_W-1:0] dout  [2];
  logic                     sat_out;

  // combinational helpers
  logic [SUM_W:0]           amag  [2];
  logic [FP_W:0]            fr    [2];
  logic [T_W-1:0]           rfull [2];
  logic [T_W-1:0]           qfix  [2];
  logic [FULL_W-1:0]        full  [2];
  logic signed [DISP_W-1:0] dsat  [2];
  logic                     hit   [2];

  // config registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RST;
      mobility  <= MOBILITY_RST;
    end else if (cfg.valid) begin
      unique case (cfg.idx)
        REG_TIME_STEP: time_step <= cfg.data;
        REG_MOBILITY:  mobility  <= cfg.data;
        default: ;
      endcase
    end
  end

  // pipeline control
  assign en        = !vld[NST-1] || disp.ready;
  assign vtx.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], vtx.valid};
    end
  end

  avds_cordic u_cordic_a (.clk(clk), .en(en), .angle(vtx.angle_a),
                          .cos_q(cos_t[0]), .sin_q(sin_t[0]));
  avds_cordic u_cordic_b (.clk(clk), .en(en), .angle(vtx.angle_b),
                          .cos_q(cos_t[1]), .sin_q(sin_t[1]));
  avds_cordic u_cordic_c (.clk(clk), .en(en), .angle(vtx.angle_c),
                          .cos_q(cos_t[2]), .sin_q(sin_t[2]));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trig[0][k] = cos_t[k];
      trig[1][k] = sin_t[k];
    end
    mot[0] = sd[T0].mot_a;
    mot[1] = sd[T0].mot_b;
    mot[2] = sd[T0].mot_c;
    frc[0] = sd[T0].fx;
    frc[1] = sd[T0].fy;
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      amag[a]  = (sum[a][SUM_W-1] ? (SUM_W+1)'(-sum[a]) : (SUM_W+1)'(sum[a]))
               + (SUM_W+1)'(HALF_D);
      fr[a]    = (FP_W+1)'(fp[a]) + (FP_W+1)'(128);
      rfull[a] = t4[a] - tr4[a][2*T_W-1:T_W] - (tr4[a][2*T_W-1:T_W] << 1);
      qfix[a]  = q05[a] + T_W'(r5[a] >= 3'd3);
      full[a]  = (FULL_W'(phi9[a]) << LO_W) + FULL_W'(plo9[a]) + FULL_W'(32'h8000);
      hit[a]   = 1'b0;
      if (ineg10[a]) begin
        if (om10[a] > OM_W'(64'h8000_0000)) begin
          dsat[a] = {1'b1, {(DISP_W-1){1'b0}}};
          hit[a]  = 1'b1;
        end else begin
          dsat[a] = -$signed(om10[a][DISP_W-1:0]);
        end
      end else begin
        if (om10[a] > OM_W'(64'h7FFF_FFFF)) begin
          dsat[a] = {1'b0, {(DISP_W-1){1'b1}}};
          hit[a]  = 1'b1;
        end else begin
          dsat[a] = $signed(om10[a][DISP_W-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // side data alongside the CORDIC
      sd[0] <= '{mot_a: vtx.motility_a, mot_b: vtx.motility_b, mot_c: vtx.motility_c,
                 fx: vtx.force_x, fy: vtx.force_y, last: vtx.last_vertex};
      for (int i = 1; i < CORDIC_LAT; i++) begin
        sd[i] <= sd[i-1];
      end
      last_d <= {last_d[9:0], sd[T0].last};

      for (int a = 0; a < 2; a++) begin
        // D1: motility * trig, force magnitude
        for (int k = 0; k < 3; k++) begin
          prod[a][k] <= $signed({1'b0, mot[k]}) * trig[a][k];
        end
        fmag[a]  <= frc[a][FORCE_W-1] ? FORCE_W'(-frc[a]) : FORCE_W'(frc[a]);
        fneg1[a] <= frc[a][FORCE_W-1];
        // D2: director sum, mu * |force|
        sum[a]   <= SUM_W'(prod[a][0]) + SUM_W'(prod[a][1]) + SUM_W'(prod[a][2]);
        fp[a]    <= fmag[a] * mobility;
        fneg2[a] <= fneg1[a];
        // D3: |sum| + D/2 over 2^K, force term rounded
        t3[a]    <= T_W'(amag[a] >> K_SH);
        sneg3[a] <= sum[a][SUM_W-1];
        ft3[a]   <= fneg2[a] ? -$signed({1'b0, fr[a][FP_W:8]})
                             :  $signed({1'b0, fr[a][FP_W:8]});
        // D4: reciprocal of three
        tr4[a]   <= t3[a] * RECIP3;
        t4[a]    <= t3[a];
        sneg4[a] <= sneg3[a];
        ft4[a]   <= ft3[a];
        // D5: estimate and remainder
        q05[a]   <= tr4[a][2*T_W-1:T_W];
        r5[a]    <= rfull[a][2:0];
        sneg5[a] <= sneg4[a];
        ft5[a]   <= ft4[a];
        // D6: corrected quotient, signed director
        dir6[a]  <= sneg5[a] ? -$signed({1'b0, qfix[a]}) : $signed({1'b0, qfix[a]});
        ft6[a]   <= ft5[a];
        // D7: director + force term
        inx7[a]  <= INX_W'(dir6[a]) + INX_W'(ft6[a]);
        // D8: magnitude
        imag8[a] <= inx7[a][INX_W-1] ? INX_W'(-inx7[a]) : INX_W'(inx7[a]);
        ineg8[a] <= inx7[a][INX_W-1];
        // D9: dt * |sum| in two partial products
        plo9[a]  <= time_step * imag8[a][LO_W-1:0];
        phi9[a]  <= time_step * imag8[a][INX_W-1:LO_W];
        ineg9[a] <= ineg8[a];
        // D10: combine and round
        om10[a]   <= full[a][FULL_W-1:16];
        ineg10[a] <= ineg9[a];
        // D11: saturate
        dout[a]  <= dsat[a];
      end
      sat_out <= hit[0] || hit[1];
    end
  end

  assign disp.valid     = vld[NST-1];
  assign disp.disp_x    = dout[0];
  assign disp.disp_y    = dout[1];
  assign disp.sweep_end = last_d[10];
  assign disp.saturated = sat_out;

endmodule

// ===== rtl/avds_cordic.sv =====
// ----------------------------------------------------------------------------
// avds_cordic
// Pipelined rotation CORDIC: phase in, cos and sin out in Q1.TRIG_FRAC_BITS.
// ----------------------------------------------------------------------------
module avds_cordic import avds_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [ANGLE_W-1:0] angle,
  output trig_t              cos_q,
  output trig_t              sin_q
);

  localparam int RS = 30 - TRIG_FRAC_BITS;

  logic [31:0] ang_ext;
  logic [31:0] p32;
  logic [31:0] shifted;

  cordic_word_t x [CORDIC_STAGES+1];
  cordic_word_t y [CORDIC_STAGES+1];
  cordic_word_t z [CORDIC_STAGES+1];
  quad_t        q [CORDIC_STAGES+1];

  cordic_word_t xs [CORDIC_STAGES][CORDIC_PER_STAGE+1];
  cordic_word_t ys [CORDIC_STAGES][CORDIC_PER_STAGE+1];
  cordic_word_t zs [CORDIC_STAGES][CORDIC_PER_STAGE+1];

  logic signed [32:0] xe;
  logic signed [32:0] ye;
  logic signed [32:0] cx_next;
  logic signed [32:0] cy_next;
  logic signed [32:0] cx;
  logic signed [32:0] cy;

  function automatic trig_t round_clamp(input logic signed [32:0] v);
    logic [32:0]             mag;
    logic [32:0]             rnd;
    logic signed [TRIG_W-1:0] r;
    mag = v[32] ? 33'(-v) : 33'(v);
    rnd = (mag + (33'd1 << (RS - 1))) >> RS;
    if (rnd > (33'd1 << TRIG_FRAC_BITS)) begin
      rnd = 33'd1 << TRIG_FRAC_BITS;
    end
    r = $signed(rnd[TRIG_W-1:0]);
    return v[32] ? -r : r;
  endfunction

  // phase to 32-bit turn, nearest quarter picks the quadrant
  assign ang_ext = 32'(angle);
  assign p32     = ang_ext << (32 - ANGLE_BITS);
  assign shifted = p32 + 32'h2000_0000;

  always_comb begin
    for (int s = 0; s < CORDIC_STAGES; s++) begin
      xs[s][0] = x[s];
      ys[s][0] = y[s];
      zs[s][0] = z[s];
      for (int k = 0; k < CORDIC_PER_STAGE; k++) begin
        if (!zs[s][k][31]) begin
          xs[s][k+1] = xs[s][k] - (ys[s][k] >>> (s * CORDIC_PER_STAGE + k));
          ys[s][k+1] = ys[s][k] + (xs[s][k] >>> (s * CORDIC_PER_STAGE + k));
          zs[s][k+1] = zs[s][k] - ATAN_TURN[s * CORDIC_PER_STAGE + k];
        end else begin
          xs[s][k+1] = xs[s][k] + (ys[s][k] >>> (s * CORDIC_PER_STAGE + k));
          ys[s][k+1] = ys[s][k] - (xs[s][k] >>> (s * CORDIC_PER_STAGE + k));
          zs[s][k+1] = zs[s][k] + ATAN_TURN[s * CORDIC_PER_STAGE + k];
        end
      end
    end
  end

  assign xe = 33'(x[CORDIC_STAGES]);
  assign ye = 33'(y[CORDIC_STAGES]);

  always_comb begin
    case (q[CORDIC_STAGES])
      QUAD_0: begin
        cx_next = xe;
        cy_next = ye;
      end
      QUAD_90: begin
        cx_next = -ye;
        cy_next = xe;
      end
      QUAD_180: begin
        cx_next = -xe;
        cy_next = -ye;
      end
      default: begin
        cx_next = ye;
        cy_next = -xe;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= CORDIC_GAIN;
      y[0] <= '0;
      z[0] <= $signed({2'b00, shifted[29:0]}) - 32'sh2000_0000;
      q[0] <= quad_t'(shifted[31:30]);
      for (int s = 0; s < CORDIC_STAGES; s++) begin
        x[s+1] <= xs[s][CORDIC_PER_STAGE];
        y[s+1] <= ys[s][CORDIC_PER_STAGE];
        z[s+1] <= zs[s][CORDIC_PER_STAGE];
        q[s+1] <= q[s];
      end
      cx    <= cx_next;
      cy    <= cy_next;
      cos_q <= round_clamp(cx);
      sin_q <= round_clamp(cy);
    end
  end

endmodule
